@@ rtl/core/bma_pkg.sv @@
// Shared types and constants for the boxcar moving average block.
package bma_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int WINDOW_FIELD_W = 9;
   localparam int WINDOW_RESET = 256;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic CSR_WINDOW_SIZE = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE
   } bma_state_type;

endpackage

@@ rtl/core/bma_window.sv @@
// Ring store of recent samples with write pointer, fill count and running sum.
module bma_window
   import bma_pkg::*;
#(
   parameter int WINDOW_MAX = 256,
   parameter int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
   parameter int CNT_W = $clog2(WINDOW_MAX + 1),
   parameter int SUM_W = SAMPLE_W + CNT_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       load,
   input  logic                       update,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic        [CNT_W-1:0]    window_size,
   output logic signed [SUM_W-1:0]    sum,
   output logic        [CNT_W-1:0]    fill
);

   logic signed [SAMPLE_W-1:0] store_mem [WINDOW_MAX];
   logic signed [SAMPLE_W-1:0] old_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] ptr_next;
   logic full;

   always_ff @(posedge clock) begin
      if (update) begin
         store_mem[ptr_ff] <= sample_ff;
      end
      old_ff <= store_mem[ptr_ff];
      if (load) begin
         sample_ff <= sample;
      end
   end

   always_comb begin
      full = (fill_ff >= window_size);
      ptr_next = CNT_W'(ptr_ff) + CNT_W'(1);
      ptr_in = ptr_ff;
      fill_in = fill_ff;
      sum_in = sum_ff;
      if (clear) begin
         ptr_in = '0;
         fill_in = '0;
         sum_in = '0;
      end else if (update) begin
         if (ptr_next >= window_size) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_next[PTR_W-1:0];
         end
         if (!full) begin
            fill_in = fill_ff + CNT_W'(1);
         end
         sum_in = sum_ff + SUM_W'(sample_ff)
                  - (full ? SUM_W'(old_ff) : SUM_W'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         fill_ff <= '0;
         sum_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         fill_ff <= fill_in;
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;
   assign fill = fill_ff;

endmodule

@@ rtl/core/bma_divider.sv @@
// Radix-2 restoring divider of the signed running sum by the fill count.
module bma_divider
   import bma_pkg::*;
#(
   parameter int CNT_W = 9,
   parameter int SUM_W = SAMPLE_W + CNT_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_W-1:0]    dividend,
   input  logic        [CNT_W-1:0]    divisor,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] quotient
);

   localparam int ITER_W = $clog2(SUM_W + 1);

   logic [ITER_W-1:0] iter_ff, iter_in;
   logic done_ff, done_in;
   logic neg_ff, neg_in;
   logic [CNT_W-1:0] divisor_ff, divisor_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W:0] rem_shift;
   logic [CNT_W:0] diff;
   logic [SAMPLE_W-1:0] mag;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      diff = rem_shift - {1'b0, divisor_ff};
      iter_in = iter_ff;
      done_in = done_ff;
      neg_in = neg_ff;
      divisor_in = divisor_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         iter_in = ITER_W'(SUM_W);
         done_in = 1'b0;
         neg_in = dividend[SUM_W-1];
         divisor_in = divisor;
         rem_in = '0;
         quo_in = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
      end else if (iter_ff != '0) begin
         iter_in = iter_ff - ITER_W'(1);
         if (!diff[CNT_W]) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         if (iter_ff == ITER_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         iter_ff <= iter_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      divisor_ff <= divisor_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign mag = quo_ff[SAMPLE_W-1:0];
   assign quotient = neg_ff ? (~mag + SAMPLE_W'(1)) : mag;
   assign done = done_ff;

endmodule

@@ rtl/core/boxcar_moving_average.sv @@
// Top level of the boxcar moving average: sequencer, register port and result register.
// A push request is accepted in the idle state, which loads its sample; the update state
// writes it into the sample store and updates the running sum, the load state starts the
// shared restoring divider, and the divider produces one quotient bit per cycle over the
// width of the running sum (SUM_W = 16 + clog2(WINDOW_MAX + 1)). The average is then
// handed to the result register, later while it still holds an earlier average under
// rsp_stall, and the sequencer returns to idle for the next request; new requests are
// stalled until then. A clear request empties the window without leaving the idle state
// and produces no result. The result register lets the next request start while an
// average still waits to be taken. Writing window_size empties the window; of the low
// WINDOW_FIELD_W bits used, 0 is taken as 1 and values above WINDOW_MAX as WINDOW_MAX.
module boxcar_moving_average
   import bma_pkg::*;
#(
   parameter int WINDOW_MAX = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;
   localparam int WINDOW_INIT = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

   bma_state_type state_ff, state_in;
   logic [CNT_W-1:0] window_ff, window_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_average_ff, rsp_average_in;
   logic req_accept;
   logic csr_write;
   logic [CSR_DATA_W-1:0] window_value;
   logic win_clear;
   logic win_load;
   logic win_update;
   logic div_start;
   logic div_done;
   logic signed [SAMPLE_W-1:0] div_quotient;
   logic signed [SUM_W-1:0] win_sum;
   logic [CNT_W-1:0] win_fill;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr[2] == CSR_WINDOW_SIZE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_WINDOW_SIZE) ? CSR_DATA_W'(window_ff) : '0;

   always_comb begin
      window_value = {{(CSR_DATA_W - WINDOW_FIELD_W){1'b0}},
                      csr_pwdata[WINDOW_FIELD_W-1:0]};
      window_in = window_ff;
      if (csr_write) begin
         if (window_value == '0) begin
            window_in = CNT_W'(1);
         end else if (window_value > CSR_DATA_W'(WINDOW_MAX)) begin
            window_in = CNT_W'(WINDOW_MAX);
         end else begin
            window_in = window_value[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         window_ff <= CNT_W'(WINDOW_INIT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         window_ff <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_average_ff <= rsp_average_in;
   end

   always_comb begin
      state_in = state_ff;
      win_clear = csr_write;
      win_load = 1'b0;
      win_update = 1'b0;
      div_start = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_average_in = rsp_average_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_operation == OP_CLEAR) begin
                  win_clear = 1'b1;
               end else begin
                  win_load = 1'b1;
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            win_update = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            div_start = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done && !(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_average_in = div_quotient;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   bma_window #(
      .WINDOW_MAX (WINDOW_MAX),
      .PTR_W      (PTR_W),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .clear       (win_clear),
      .load        (win_load),
      .update      (win_update),
      .sample      (req_sample),
      .window_size (window_ff),
      .sum         (win_sum),
      .fill        (win_fill)
   );

   bma_divider #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (win_sum),
      .divisor  (win_fill),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

endmodule
